FILE: rtl/bfp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfp_pkg
// shared widths, fixed bearings, item types and the cordic angle table
// ---------------------------------------------------------------------------
package bfp_pkg;

    localparam int COORD_W         = 16;
    localparam int BEARING_W       = 15;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STAGES   = 16;
    localparam int ATAN_LEN        = 24;
    localparam int ATAN_IDX_W      = 5;
    localparam int NUM_ITER        = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int Z_FRAC          = 16;

    // x and y grow by the cordic gain times sqrt(2) over a 32-bit start value
    localparam int XY_W = COORD_W + Z_FRAC + 4;
    // angle accumulator in 2^-16 degree, sum of the table stays below 2^23
    localparam int Z_W  = 25;

    // bearings on the axes, masked to the result width
    localparam logic [BEARING_W-1:0] BEARING_E    = BEARING_W'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [BEARING_W-1:0] BEARING_S    = BEARING_W'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [BEARING_W-1:0] BEARING_W_DIR = BEARING_W'(270 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [BEARING_W-1:0] BEARING_N    = BEARING_W'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [BEARING_W-1:0] BEARING_SAME = '0;

    typedef struct packed {
        logic                 use_cordic;
        logic                 dx_pos;
        logic                 dy_neg;
        logic [BEARING_W-1:0] fixed_bearing;
    } bfp_tag_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        bfp_tag_t               tag;
    } bfp_item_t;

    // atan(2^-i) in degrees, scaled by 2^16 and rounded
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 25'sd2949120;
            5'd1:    val = 25'sd1740967;
            5'd2:    val = 25'sd919879;
            5'd3:    val = 25'sd466945;
            5'd4:    val = 25'sd234379;
            5'd5:    val = 25'sd117304;
            5'd6:    val = 25'sd58666;
            5'd7:    val = 25'sd29335;
            5'd8:    val = 25'sd14668;
            5'd9:    val = 25'sd7334;
            5'd10:   val = 25'sd3667;
            5'd11:   val = 25'sd1833;
            5'd12:   val = 25'sd917;
            5'd13:   val = 25'sd458;
            5'd14:   val = 25'sd229;
            5'd15:   val = 25'sd115;
            5'd16:   val = 25'sd57;
            5'd17:   val = 25'sd29;
            5'd18:   val = 25'sd14;
            5'd19:   val = 25'sd7;
            5'd20:   val = 25'sd4;
            5'd21:   val = 25'sd2;
            5'd22:   val = 25'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bfp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfp_if
// valid/ready channels for point-pair requests and bearing results
// ---------------------------------------------------------------------------
interface bfp_req_if import bfp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

interface bfp_rsp_if import bfp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BEARING_W-1:0] bearing;

    modport source (output valid, output bearing, input ready);
    modport sink   (input valid, input bearing, output ready);
endinterface
`default_nettype wire

FILE: rtl/bfp_cordic.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfp_cordic
// vectoring cordic, one registered iteration per stage, stall per stage
// ---------------------------------------------------------------------------
module bfp_cordic import bfp_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      src_valid,
    output logic           src_ready,
    input  wire bfp_item_t src_item,
    output logic           dst_valid,
    input  wire logic      dst_ready,
    output bfp_item_t      dst_item
);

    bfp_item_t                 stg_item_reg  [NUM_ITER];
    bfp_item_t                 stg_item_next [NUM_ITER];
    logic      [NUM_ITER-1:0]  stg_vld_reg;
    bfp_item_t                 pre_item      [NUM_ITER];
    logic      [NUM_ITER-1:0]  pre_vld;
    logic      [NUM_ITER:0]    rdy;

    assign rdy[NUM_ITER] = dst_ready;
    assign src_ready     = rdy[0];
    assign dst_valid     = stg_vld_reg[NUM_ITER-1];
    assign dst_item      = stg_item_reg[NUM_ITER-1];

    for (genvar k = 0; k < NUM_ITER; k++) begin : g_stage
        logic signed [XY_W-1:0] xi;
        logic signed [XY_W-1:0] yi;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0]  zi;
        logic signed [Z_W-1:0]  ang;

        if (k == 0) begin : g_first
            assign pre_item[k] = src_item;
            assign pre_vld[k]  = src_valid;
        end
        else begin : g_next
            assign pre_item[k] = stg_item_reg[k-1];
            assign pre_vld[k]  = stg_vld_reg[k-1];
        end

        // a stage takes new data when empty or when its content moves on
        assign rdy[k] = !stg_vld_reg[k] || rdy[k+1];

        always_comb
        begin
            xi  = pre_item[k].x;
            yi  = pre_item[k].y;
            zi  = pre_item[k].z;
            xs  = xi >>> k;
            ys  = yi >>> k;
            ang = atan_q16(ATAN_IDX_W'(k));
            stg_item_next[k].tag = pre_item[k].tag;
            if (!yi[XY_W-1])
            begin
                stg_item_next[k].x = xi + ys;
                stg_item_next[k].y = yi - xs;
                stg_item_next[k].z = zi + ang;
            end
            else
            begin
                stg_item_next[k].x = xi - ys;
                stg_item_next[k].y = yi + xs;
                stg_item_next[k].z = zi - ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                stg_vld_reg[k] <= pre_vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && pre_vld[k])
            begin
                stg_item_reg[k] <= stg_item_next[k];
            end
        end
    end

    // a free output frees the whole chain back to the input
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        dst_ready |-> src_ready)
        else $error("cordic input blocked while output is free");

    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_item))
        else $error("stalled cordic result changed");

endmodule
`default_nettype wire

FILE: rtl/bearing_from_two_points.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bearing_from_two_points
// compass bearing of an end point seen from a start point
// ---------------------------------------------------------------------------
// Takes one point pair per request and returns the compass bearing in
// 2^-ANGLE_FRAC_BITS degree (1/64 degree by default), y growing to the south.
// Pairs on an axis give fixed bearings: east 90, south 180, west 270,
// north 360 (not 0); identical points give 0. Other pairs find
// t = atan(|dy|/|dx|) with a vectoring cordic and return 90-t, 90+t, 270-t
// or 270+t by quadrant. Throughput is one request per clock cycle unless
// the result side stalls. The pipeline is one front stage for differences
// and classification, one register stage per cordic iteration, and one
// output stage for clamp, rounding and quadrant mapping. Every stage holds
// its own valid bit, so bubbles are squeezed out while the result side
// stalls, and a new request is taken while a finished result still waits.
// ---------------------------------------------------------------------------
module bearing_from_two_points import bfp_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    bfp_req_if.sink   req,
    bfp_rsp_if.source rsp
);

    localparam int SH         = Z_FRAC - ANGLE_FRAC_BITS;
    localparam int ROUND_HALF = (SH > 0) ? (2 ** (SH - 1)) : 0;
    localparam int T_W        = 8 + ANGLE_FRAC_BITS;
    localparam int RES_W      = 10 + ANGLE_FRAC_BITS;

    localparam logic signed [Z_W-1:0] Z_MAX   = Z_W'(90 * (2 ** Z_FRAC));
    localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(ROUND_HALF);
    localparam logic [RES_W-1:0]      R90     = RES_W'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [RES_W-1:0]      R270    = RES_W'(270 * (2 ** ANGLE_FRAC_BITS));

    // front stage: differences, magnitudes, axis cases
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic        [COORD_W:0]   dx_mag;
    logic        [COORD_W:0]   dy_mag;
    logic                      dx_zero;
    logic                      dy_zero;
    bfp_item_t                 frt_item_next;
    bfp_item_t                 frt_item_reg;
    logic                      frt_vld_reg;
    logic                      frt_ready;

    // cordic pipeline handshake
    logic                      crd_src_ready;
    logic                      crd_dst_valid;
    logic                      crd_dst_ready;
    bfp_item_t                 crd_dst_item;

    // output stage
    logic signed [Z_W-1:0]     z_clamp;
    logic signed [Z_W-1:0]     z_round;
    logic        [T_W-1:0]     t_val;
    logic        [RES_W-1:0]   res;
    logic        [BEARING_W-1:0] bearing_next;
    logic        [BEARING_W-1:0] bearing_reg;
    logic                      rsp_vld_reg;

    always_comb
    begin
        dx      = {req.end_x[COORD_W-1], req.end_x} - {req.start_x[COORD_W-1], req.start_x};
        dy      = {req.end_y[COORD_W-1], req.end_y} - {req.start_y[COORD_W-1], req.start_y};
        dx_mag  = dx[COORD_W] ? (~dx + 1'b1) : dx;
        dy_mag  = dy[COORD_W] ? (~dy + 1'b1) : dy;
        dx_zero = (dx == '0);
        dy_zero = (dy == '0);

        // start vector is (|dx|, |dy|) scaled by 2^16, angle zero
        frt_item_next.x = XY_W'({dx_mag[COORD_W-1:0], {Z_FRAC{1'b0}}});
        frt_item_next.y = XY_W'({dy_mag[COORD_W-1:0], {Z_FRAC{1'b0}}});
        frt_item_next.z = '0;

        frt_item_next.tag.use_cordic    = 1'b0;
        frt_item_next.tag.dx_pos        = !dx[COORD_W];
        frt_item_next.tag.dy_neg        = dy[COORD_W];
        frt_item_next.tag.fixed_bearing = BEARING_SAME;

        if (dx_zero && dy_zero)
        begin
            frt_item_next.tag.fixed_bearing = BEARING_SAME;
        end
        else if (dy_zero)
        begin
            // due east or due west
            frt_item_next.tag.fixed_bearing = dx[COORD_W] ? BEARING_W_DIR : BEARING_E;
        end
        else if (dx_zero)
        begin
            // due north (smaller y) or due south
            frt_item_next.tag.fixed_bearing = dy[COORD_W] ? BEARING_N : BEARING_S;
        end
        else
        begin
            frt_item_next.tag.use_cordic = 1'b1;
        end
    end

    assign frt_ready = !frt_vld_reg || crd_src_ready;
    assign req.ready = frt_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frt_vld_reg <= 1'b0;
        end
        else if (frt_ready)
        begin
            frt_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frt_ready && req.valid)
        begin
            frt_item_reg <= frt_item_next;
        end
    end

    // one iteration per register stage
    bfp_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (frt_vld_reg),
        .src_ready (crd_src_ready),
        .src_item  (frt_item_reg),
        .dst_valid (crd_dst_valid),
        .dst_ready (crd_dst_ready),
        .dst_item  (crd_dst_item)
    );

    // clamp the angle to [0, 90] degree, round to the output grid, map quadrant
    always_comb
    begin
        if (crd_dst_item.z[Z_W-1])
        begin
            z_clamp = '0;
        end
        else if (crd_dst_item.z > Z_MAX)
        begin
            z_clamp = Z_MAX;
        end
        else
        begin
            z_clamp = crd_dst_item.z;
        end
        z_round = z_clamp + Z_ROUND;
        t_val   = T_W'(z_round >>> SH);

        if (crd_dst_item.tag.dx_pos)
        begin
            res = crd_dst_item.tag.dy_neg ? (R90 - RES_W'(t_val)) : (R90 + RES_W'(t_val));
        end
        else
        begin
            res = crd_dst_item.tag.dy_neg ? (R270 + RES_W'(t_val)) : (R270 - RES_W'(t_val));
        end

        bearing_next = crd_dst_item.tag.use_cordic ? BEARING_W'(res)
                                                   : crd_dst_item.tag.fixed_bearing;
    end

    // output register parts result side from the pipeline
    assign crd_dst_ready = !rsp_vld_reg || rsp.ready;
    assign rsp.valid     = rsp_vld_reg;
    assign rsp.bearing   = bearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (crd_dst_ready)
        begin
            rsp_vld_reg <= crd_dst_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (crd_dst_ready && crd_dst_valid)
        begin
            bearing_reg <= bearing_next;
        end
    end

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frt_vld_reg && !crd_src_ready |=> frt_vld_reg && $stable(frt_item_reg))
        else $error("stalled front stage lost or changed its request");

    a_fixed_pass: assert property (@(posedge clk) disable iff (!rst_n)
        crd_dst_valid && crd_dst_ready && !crd_dst_item.tag.use_cordic
        |=> rsp.valid && (rsp.bearing == $past(crd_dst_item.tag.fixed_bearing)))
        else $error("axis bearing altered on its way to the output");

endmodule
`default_nettype wire
